[rtl/tdp_pkg.sv]
// ----------------------------------------------------------------------------
// Trial division primality test: shared package
// Status types passed between the sequencer and the remainder unit.
// ----------------------------------------------------------------------------
package tdp_pkg;

  typedef struct packed {
    logic done;
    logic zero_rem;
  } div_stat_t;

  localparam int unsigned OUT_BYTES_W = 8;

endpackage

[rtl/tdp_divider.sv]
// ----------------------------------------------------------------------------
// Trial division primality test: remainder unit
// Restoring division, one quotient bit per cycle, reporting a zero remainder.
// ----------------------------------------------------------------------------
module tdp_divider #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [NUMBER_WIDTH-1:0] dividend,
  input  logic [NUMBER_WIDTH-1:0] divisor,
  output tdp_pkg::div_stat_t      stat
);
  import tdp_pkg::*;

  localparam int CW = $clog2(NUMBER_WIDTH + 1);

  logic [NUMBER_WIDTH-1:0] rem_r, rem_nxt;
  logic [NUMBER_WIDTH-1:0] dvd_r;
  logic [NUMBER_WIDTH-1:0] dsr_r;
  logic [CW-1:0]           cnt_r;
  logic                    busy_r;
  logic                    done_r;
  logic [NUMBER_WIDTH:0]   trial;

  always_comb begin
    trial = {rem_r, dvd_r[NUMBER_WIDTH-1]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = NUMBER_WIDTH'(trial - {1'b0, dsr_r});
    end else begin
      rem_nxt = trial[NUMBER_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUMBER_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[NUMBER_WIDTH-2:0], 1'b0};
    end
  end

  assign stat.done     = done_r;
  assign stat.zero_rem = (rem_r == '0);

endmodule

[rtl/trial_division_primality_test_top.sv]
// ----------------------------------------------------------------------------
// Trial division primality test: top level
// Tests one unsigned number per item for primality by odd trial divisors.
// ----------------------------------------------------------------------------
// The input channel takes one number per item on in_tdata; only its low
// NUMBER_WIDTH bits are tested. The result channel returns one item per
// input with is_prime in out_tdata bit 0.
// Numbers below two, two itself and even numbers are answered from the check
// state without a division. An odd number is tried against the divisors 3,
// 5, 7 and so on while the divisor squared does not exceed it, the square
// being kept by a running sum. Each divisor is tried by the bit-serial
// remainder unit. Only one item is in work at a time.
// The result waits in an output register; the next item is accepted once
// that register is empty or is being emptied in the same cycle, so a stalled
// receiver holds the block idle but loses nothing.
// Reset empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module trial_division_primality_test_top #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [31:0] in_tdata,   // [31:0] number
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [tdp_pkg::OUT_BYTES_W-1:0] out_tdata  // [0] is_prime
);
  import tdp_pkg::*;

  localparam int W  = NUMBER_WIDTH;
  localparam int SW = NUMBER_WIDTH + 2;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [W-1:0]  held_r;
  logic [W-1:0]  d_r;
  logic [SW-1:0] sq_r;
  logic          out_valid_r;
  logic          out_prime_r;
  logic [W-1:0]  n_in;
  logic          in_fire;
  logic          div_start;
  div_stat_t     div_stat;

  if (NUMBER_WIDTH <= 32) begin : g_narrow
    assign n_in = in_tdata[NUMBER_WIDTH-1:0];
  end else begin : g_wide
    assign n_in = {{(NUMBER_WIDTH - 32){1'b0}}, in_tdata};
  end

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign div_start = (state_r == S_CHECK) && !(sq_r > {2'b00, held_r});

  tdp_divider #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (held_r),
    .divisor  (d_r),
    .stat     (div_stat)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (div_start) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = div_stat.zero_rem ? S_IDLE : S_CHECK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == S_CHECK && !div_start) ||
          (state_r == S_DIV && div_stat.done && div_stat.zero_rem)) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // Odd numbers of three and up go to the divisor loop; all others are
  // settled by forcing the square above the number with a fixed answer.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      held_r <= n_in;
      d_r    <= W'(3);
      if (n_in[0] && (n_in != W'(1))) begin
        sq_r        <= SW'(9);
        out_prime_r <= 1'b1;
      end else begin
        sq_r        <= '1;
        out_prime_r <= (n_in == W'(2));
      end
    end else if (state_r == S_DIV && div_stat.done) begin
      if (div_stat.zero_rem) begin
        out_prime_r <= 1'b0;
      end else begin
        d_r  <= d_r + W'(2);
        sq_r <= sq_r + {d_r, 2'b00} + SW'(4);
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_BYTES_W - 1){1'b0}}, out_prime_r};

  a_divisor_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (d_r[0] && (d_r >= W'(3))))
    else $error("trial divisor is not an odd value of three or more");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV))
    else $error("remainder unit finished outside a division");

  a_prime_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_prime_r) |-> (held_r[0] || (held_r == W'(2))))
    else $error("even number other than two reported prime");

  a_start_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !out_valid_r)
    else $error("output register still full after an item was taken");

endmodule
